// ===== hw/rtl/tts_pkg.sv =====
// Types and codes shared by the tick task scheduler modules.
package tts_pkg;

    // Input word kinds; the fourth code is ignored
    typedef enum logic [1:0] {
        KIND_TICK = 2'd0,
        KIND_ADD  = 2'd1,
        KIND_DEL  = 2'd2
    } t_kind;

    // Result status codes
    typedef enum logic [2:0] {
        STAT_ADDED   = 3'd0,
        STAT_FULL    = 3'd1,
        STAT_DELETED = 3'd2,
        STAT_BAD     = 3'd3,
        STAT_DUE     = 3'd4
    } t_status;

    // Sequencer states
    typedef enum logic {
        ST_IDLE  = 1'b0,
        ST_SWEEP = 1'b1
    } t_state;

    // Input word
    typedef struct packed {
        t_kind       kind;
        logic [7:0]  task_code;
        logic [15:0] start_delay;
        logic [15:0] repeat_period;
        logic [3:0]  slot_number;
    } t_in_word;

    // Result word
    typedef struct packed {
        t_status    status;
        logic [3:0] slot_out;
        logic [7:0] task_out;
        logic       last;
    } t_out_word;

    // Decision of the slot update unit for one slot
    typedef struct packed {
        logic due;      // slot fires this tick
        logic retire;   // one-shot slot is freed after firing
    } t_slot_op;

endpackage

// ===== hw/rtl/tts_slot_alu.sv =====
// Shared slot update unit: countdown, due test and period reload for one slot.
module tts_slot_alu
    import tts_pkg::*;
#(
    parameter int DELAY_BITS = 16
) (
    input  logic                  i_valid,
    input  logic [DELAY_BITS-1:0] i_rem,
    input  logic [DELAY_BITS-1:0] i_reload,
    output t_slot_op              o_op,
    output logic [DELAY_BITS-1:0] o_next_rem
);

    logic w_due;
    logic w_periodic;

    // A count of one or less means the slot fires on this tick
    assign w_due      = i_valid && (i_rem <= DELAY_BITS'(1));
    assign w_periodic = (i_reload != '0);

    always_comb begin
        o_op.due    = w_due;
        o_op.retire = w_due && !w_periodic;
        if (w_due) begin
            o_next_rem = w_periodic ? i_reload : i_rem;
        end else begin
            o_next_rem = i_rem - DELAY_BITS'(1);
        end
    end

endmodule

// ===== hw/rtl/tick_task_scheduler.sv =====
// Tick task scheduler top level: slot table, sweep sequencer and result register.
// Add and delete words: one result word, registered in the cycle after acceptance.
// Tick words: one slot per cycle through a shared update unit, unless a due result
//   waits on i_out_ready; o_in_ready stays low until the sweep has passed every slot.
// Ticks wait for the sweep to end; add/delete words one per cycle if i_out_ready is high.
// Synchronous active-low reset clears the slot valid bits and control at once.
module tick_task_scheduler
    import tts_pkg::*;
#(
    parameter int SLOTS      = 8,
    parameter int DELAY_BITS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_word o_out_word
);

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [DELAY_BITS-1:0] DMAX = '1;

    // Slot table
    logic [SLOTS-1:0]      r_valid;
    logic [DELAY_BITS-1:0] r_rem    [SLOTS];
    logic [DELAY_BITS-1:0] r_reload [SLOTS];
    logic [7:0]            r_task   [SLOTS];

    // Sequencer and result register
    t_state           r_state, n_state;
    logic [IW-1:0]    r_idx, n_idx;
    logic [SLOTS-1:0] r_due, n_due;
    logic             r_out_valid, n_out_valid;
    t_out_word        r_out, n_out;

    logic             w_in_acc;
    logic             w_out_free;
    logic             w_sweep_step;
    logic             w_sweep_end;
    logic             w_full;
    logic [IW-1:0]    w_free_idx;
    logic             w_bad;
    logic [IW-1:0]    w_del_idx;
    logic [DELAY_BITS-1:0] w_start_sat;
    logic [DELAY_BITS-1:0] w_period_sat;
    logic [15:0]      w_start_fix;
    logic [SLOTS-1:0] w_higher;
    logic             w_last;
    t_slot_op         w_op;
    logic [DELAY_BITS-1:0] w_next_rem;

    assign w_out_free  = !r_out_valid || i_out_ready;
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_sweep_end = (r_idx == IW'(SLOTS - 1));
    // A due slot waits while the result register is still held
    assign w_sweep_step = (r_state == ST_SWEEP) && (!w_op.due || w_out_free);

    // Shared update unit, fed by the slot under the sweep index
    tts_slot_alu #(
        .DELAY_BITS (DELAY_BITS)
    ) u_alu (
        .i_valid    (r_valid[r_idx]),
        .i_rem      (r_rem[r_idx]),
        .i_reload   (r_reload[r_idx]),
        .o_op       (w_op),
        .o_next_rem (w_next_rem)
    );

    // Lowest free slot
    always_comb begin
        w_free_idx = '0;
        for (int s = SLOTS - 1; s >= 0; s--) begin
            if (!r_valid[s]) begin
                w_free_idx = IW'(s);
            end
        end
    end
    assign w_full = &r_valid;

    // Delete range check
    assign w_bad     = ({1'b0, i_in_word.slot_number} >= 5'(SLOTS));
    assign w_del_idx = IW'(i_in_word.slot_number);

    // Zero start delay counts as one; saturate both counts to the counter width
    assign w_start_fix  = (i_in_word.start_delay == '0) ? 16'd1 : i_in_word.start_delay;
    assign w_start_sat  = ({17'b0, w_start_fix} > 33'(DMAX)) ? DMAX
                          : DELAY_BITS'(w_start_fix);
    assign w_period_sat = ({17'b0, i_in_word.repeat_period} > 33'(DMAX)) ? DMAX
                          : DELAY_BITS'(i_in_word.repeat_period);

    // Last flag: no slot above the sweep index was due at tick start
    always_comb begin
        for (int s = 0; s < SLOTS; s++) begin
            w_higher[s] = (IW'(s) > r_idx);
        end
    end
    assign w_last = ~|(r_due & w_higher);

    // Next state
    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        case (r_state)
            ST_IDLE: begin
                n_idx = '0;
                if (w_in_acc && (i_in_word.kind == KIND_TICK)) begin
                    n_state = ST_SWEEP;
                end
            end
            ST_SWEEP: begin
                if (w_sweep_step) begin
                    if (w_sweep_end) begin
                        n_state = ST_IDLE;
                        n_idx   = '0;
                    end else begin
                        n_idx = r_idx + IW'(1);
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
                n_idx   = '0;
            end
        endcase
    end

    // Outputs and result register
    always_comb begin
        o_in_ready  = (r_state == ST_IDLE) && w_out_free;
        n_due       = r_due;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        case (r_state)
            ST_IDLE: begin
                for (int s = 0; s < SLOTS; s++) begin
                    n_due[s] = r_valid[s] && (r_rem[s] <= DELAY_BITS'(1));
                end
                if (w_in_acc) begin
                    case (i_in_word.kind)
                        KIND_ADD: begin
                            n_out_valid = 1'b1;
                            n_out.task_out = '0;
                            n_out.last     = 1'b1;
                            if (w_full) begin
                                n_out.status   = STAT_FULL;
                                n_out.slot_out = '0;
                            end else begin
                                n_out.status   = STAT_ADDED;
                                n_out.slot_out = 4'(w_free_idx);
                            end
                        end
                        KIND_DEL: begin
                            n_out_valid    = 1'b1;
                            n_out.status   = w_bad ? STAT_BAD : STAT_DELETED;
                            n_out.slot_out = i_in_word.slot_number;
                            n_out.task_out = '0;
                            n_out.last     = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SWEEP: begin
                if (w_sweep_step && w_op.due) begin
                    n_out_valid    = 1'b1;
                    n_out.status   = STAT_DUE;
                    n_out.slot_out = 4'(r_idx);
                    n_out.task_out = r_task[r_idx];
                    n_out.last     = w_last;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_idx       <= '0;
            r_due       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_due       <= n_due;
            r_out_valid <= n_out_valid;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    // Slot valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (w_in_acc && (i_in_word.kind == KIND_ADD) && !w_full) begin
            r_valid[w_free_idx] <= 1'b1;
        end else if (w_in_acc && (i_in_word.kind == KIND_DEL) && !w_bad) begin
            r_valid[w_del_idx] <= 1'b0;
        end else if (w_sweep_step && w_op.retire) begin
            r_valid[r_idx] <= 1'b0;
        end
    end

    // Slot counts, periods and task codes
    always_ff @(posedge i_clk) begin
        if (w_in_acc && (i_in_word.kind == KIND_ADD) && !w_full) begin
            r_rem[w_free_idx]    <= w_start_sat;
            r_reload[w_free_idx] <= w_period_sat;
            r_task[w_free_idx]   <= i_in_word.task_code;
        end else if (w_sweep_step && r_valid[r_idx]) begin
            r_rem[r_idx] <= w_next_rem;
        end
    end

`ifndef ASSERT_OFF
    a_no_accept_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SWEEP) |-> !o_in_ready)
        else $error("input accepted during sweep");

    a_tick_starts_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && (i_in_word.kind == KIND_TICK)) |=> (r_state == ST_SWEEP))
        else $error("tick did not start a sweep");

    a_live_slot_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_SWEEP) && r_valid[r_idx]) |-> (r_rem[r_idx] != '0))
        else $error("valid slot with zero count");

    a_slot_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_word.status != STAT_BAD))
            |-> ({1'b0, o_out_word.slot_out} < 5'(SLOTS)))
        else $error("result slot out of range");

    a_due_matches_snapshot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SWEEP) |-> (w_op.due == r_due[r_idx]))
        else $error("due slot differs from tick snapshot");
`endif

endmodule
